[sv/gfso_pkg.sv]
package gfso_pkg;

    // Pin and field widths
    localparam int PIN_COUNT = 54;
    localparam int PIN_W     = 6;
    localparam int FN_W      = 3;
    localparam int MODE_W    = 3;

    typedef logic [PIN_COUNT-1:0] t_pins;
    typedef logic [PIN_W-1:0]     t_pin;
    typedef logic [FN_W-1:0]      t_fn;

    // Function code that makes a pin an output
    localparam t_fn FN_OUTPUT = t_fn'(1);

    // Output levels after reset: low 32 pins high
    localparam t_pins LEVELS_AT_RESET = t_pins'(64'h0000_0000_FFFF_FFFF);

    typedef enum logic [MODE_W-1:0] {
        MODE_SET_FN   = 3'd0,
        MODE_GET_FN   = 3'd1,
        MODE_DRIVE    = 3'd2,
        MODE_READ_OUT = 3'd3,
        MODE_CHECK    = 3'd4
    } t_mode;

    // One request as held in the input stage
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        t_pin              pin;
        t_fn               code;
        logic              level;
    } t_item;

    // One result
    typedef struct packed {
        logic ok;
        t_fn  fn_read;
        logic fn_valid;
        logic pin_value;
        logic changed;
    } t_result;

    // Function store write port
    typedef struct packed {
        logic en;
        t_pin addr;
        t_fn  code;
    } t_fn_wr;

endpackage

[sv/gfso_fn_store.sv]
module gfso_fn_store
    import gfso_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_fn_wr i_wr,
    input  logic   i_rd_en,
    input  t_pin   i_rd_addr,
    output t_fn    o_rd_code
);

    logic [FN_W-1:0]      r_mem [PIN_COUNT];
    logic [PIN_COUNT-1:0] r_vld;
    t_fn                  r_rd_code;
    logic                 rd_in_range;
    logic                 rd_fwd;

    assign rd_in_range = i_rd_addr < PIN_W'(PIN_COUNT);
    assign rd_fwd      = i_wr.en && (i_wr.addr == i_rd_addr);

    // Write one entry and mark it valid
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // Registered read; forward a write to the same pin in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (rd_fwd) begin
                r_rd_code <= i_wr.code;
            end else if (rd_in_range && r_vld[i_rd_addr]) begin
                r_rd_code <= r_mem[i_rd_addr];
            end else begin
                r_rd_code <= '0;
            end
        end
    end

    assign o_rd_code = r_rd_code;

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |-> (i_wr.addr < PIN_W'(PIN_COUNT)))
        else $error("function store write outside pin range");

endmodule

[sv/gfso_core.sv]
module gfso_core
    import gfso_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_fn     i_rd_code,
    output t_result o_result,
    output t_fn_wr  o_wr
);

    t_pins   r_mask, n_mask;
    t_pins   r_levels, n_levels;
    t_pins   r_last, n_last;
    t_result res;
    t_fn_wr  wr;
    logic    pin_ok;
    t_pins   pin_bit;

    assign pin_ok  = i_item.pin < PIN_W'(PIN_COUNT);
    assign pin_bit = t_pins'(1) << i_item.pin;

    // Decode the mode, form the result and the next state
    always_comb begin
        res      = '0;
        wr       = '0;
        n_mask   = r_mask;
        n_levels = r_levels;
        n_last   = r_last;
        wr.addr  = i_item.pin;
        wr.code  = i_item.code;
        unique case (i_item.mode)
            MODE_SET_FN: begin
                if (pin_ok) begin
                    res.ok = 1'b1;
                    wr.en  = i_fire;
                    if (i_item.code == FN_OUTPUT) begin
                        n_mask = r_mask | pin_bit;
                    end else begin
                        n_mask = r_mask & ~pin_bit;
                    end
                end
            end
            MODE_GET_FN: begin
                if (pin_ok) begin
                    res.ok       = 1'b1;
                    res.fn_valid = 1'b1;
                    res.fn_read  = i_rd_code;
                end
            end
            MODE_DRIVE: begin
                if (pin_ok) begin
                    res.ok = 1'b1;
                    if (i_item.level) begin
                        n_levels = r_levels | pin_bit;
                    end else begin
                        n_levels = r_levels & ~pin_bit;
                    end
                end
            end
            MODE_READ_OUT: begin
                res.pin_value = 1'b1;
                if (pin_ok) begin
                    res.ok = 1'b1;
                    // Mask bit mirrors "function is output"
                    if (r_mask[i_item.pin]) begin
                        res.pin_value = r_levels[i_item.pin];
                    end
                end
            end
            MODE_CHECK: begin
                res.changed = (r_mask & r_levels) != (r_mask & r_last);
                n_last      = r_levels;
            end
            default: begin
            end
        endcase
    end

    // Commit state when the item leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_levels <= LEVELS_AT_RESET;
            r_last   <= LEVELS_AT_RESET;
        end else if (i_fire) begin
            r_mask   <= n_mask;
            r_levels <= n_levels;
            r_last   <= n_last;
        end
    end

    assign o_result = res;
    assign o_wr     = wr;

    a_snapshot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.mode == MODE_CHECK) |=> (r_last == $past(r_levels)))
        else $error("snapshot did not take the output levels");

endmodule

[sv/gpio_function_select_and_output.sv]
// Path from input transfer to result valid: input stage, then result register.
// Throughput: one item per cycle while results are taken; the function store has one
// registered read port, read as the item enters, with a same-pin write forwarded from the input stage.
// Reset (i_rst_n low, synchronous): function codes read 0, output mask clears,
// output levels and snapshot take the low 32 pins high; both stages empty.
module gpio_function_select_and_output
    import gfso_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [PIN_W-1:0] i_pin,
    input  logic [FN_W-1:0]  i_function_code,
    input  logic             i_level,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_ok,
    output logic [FN_W-1:0]  o_function_read,
    output logic             o_function_valid,
    output logic             o_pin_value,
    output logic             o_changed
);

    logic    r_s1_vld;
    t_item   r_s1;
    logic    r_out_vld;
    t_result r_out;
    logic    s1_fire;
    logic    in_xfer;
    t_fn     rd_code;
    t_result result;
    t_fn_wr  wr;

    assign s1_fire = r_s1_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_s1_vld || s1_fire;
    assign in_xfer = i_valid && o_ready;

    gfso_fn_store u_fn_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd_en   (in_xfer),
        .i_rd_addr (i_pin),
        .o_rd_code (rd_code)
    );

    gfso_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (s1_fire),
        .i_item    (r_s1),
        .i_rd_code (rd_code),
        .o_result  (result),
        .o_wr      (wr)
    );

    // Input stage: capture a transfer, drop it once it moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_ready) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1.mode  <= i_mode;
            r_s1.pin   <= i_pin;
            r_s1.code  <= i_function_code;
            r_s1.level <= i_level;
        end
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_fire) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= result;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_ok             = r_out.ok;
    assign o_function_read  = r_out.fn_read;
    assign o_function_valid = r_out.fn_valid;
    assign o_pin_value      = r_out.pin_value;
    assign o_changed        = r_out.changed;

    a_fn_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_function_valid) |-> o_ok)
        else $error("function read valid without ok");

    a_changed_no_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_changed) |-> (!o_ok && !o_function_valid))
        else $error("change flag mixed with pin result");

    a_fn_read_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_function_read != '0) |-> o_function_valid)
        else $error("function code returned without valid");

endmodule
